// File: rtl/lpa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpa_pkg
// shared types and codes of the linked pool entry allocator
// ----------------------------------------------------------------------------
package lpa_pkg;

  localparam int MODE_W = 2;
  localparam int NUM_W  = 5;
  localparam int STAT_W = 2;

  // request codes
  typedef enum logic [MODE_W-1:0] {
    MODE_ALLOC   = 2'd0,
    MODE_RELEASE = 2'd1,
    MODE_LIST    = 2'd2,
    MODE_UNUSED  = 2'd3
  } mode_t;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK         = 2'd0,
    ST_EXHAUSTED  = 2'd1,
    ST_NOT_ACTIVE = 2'd2,
    ST_EMPTY      = 2'd3
  } status_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_ALLOC,
    S_REL_WALK,
    S_REL_UNLINK,
    S_REL_FREE,
    S_LIST,
    S_EMIT
  } fsm_state_t;

  // one result word handed to the output register
  typedef struct packed {
    logic [NUM_W-1:0] num;
    status_t          status;
    logic             last;
  } res_word_t;

endpackage

// File: rtl/lpa_link_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpa_link_mem
// link store: one write port, one registered read port, per-entry valid bits
// ----------------------------------------------------------------------------
module lpa_link_mem #(
  parameter int POOL_SIZE = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             rd_en,
  input  logic [$clog2(POOL_SIZE)-1:0]     rd_addr,
  output logic [$clog2(POOL_SIZE+1)-1:0]   rd_data,
  input  logic                             wr_en,
  input  logic [$clog2(POOL_SIZE)-1:0]     wr_addr,
  input  logic [$clog2(POOL_SIZE+1)-1:0]   wr_data
);

  localparam int IDX_W = $clog2(POOL_SIZE);
  localparam int LNK_W = $clog2(POOL_SIZE + 1);

  logic [LNK_W-1:0]     mem [POOL_SIZE];
  logic [POOL_SIZE-1:0] valid_r;
  logic [LNK_W-1:0]     rd_q_r;
  logic                 rd_vld_r;
  logic [IDX_W-1:0]     rd_addr_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q_r    <= mem[rd_addr];
      rd_addr_r <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= valid_r[rd_addr];
      end
    end
  end

  // unwritten entry reads as its reset link, i+1 (last entry gives none)
  assign rd_data = rd_vld_r ? rd_q_r : (LNK_W'(rd_addr_r) + LNK_W'(1));

endmodule

// File: rtl/lpa_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpa_ctrl
// request sequencer: list heads, list walks and link store updates
// ----------------------------------------------------------------------------
module lpa_ctrl #(
  parameter int POOL_SIZE = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [lpa_pkg::MODE_W-1:0]       in_mode,
  input  logic [lpa_pkg::NUM_W-1:0]        in_entry_number,
  output logic                             rd_en,
  output logic [$clog2(POOL_SIZE)-1:0]     rd_addr,
  input  logic [$clog2(POOL_SIZE+1)-1:0]   rd_data,
  output logic                             wr_en,
  output logic [$clog2(POOL_SIZE)-1:0]     wr_addr,
  output logic [$clog2(POOL_SIZE+1)-1:0]   wr_data,
  output logic                             res_push,
  output lpa_pkg::res_word_t               res,
  input  logic                             res_ready
);

  import lpa_pkg::*;

  localparam int IDX_W = $clog2(POOL_SIZE);
  localparam int LNK_W = $clog2(POOL_SIZE + 1);
  localparam int CMP_W = (IDX_W > NUM_W) ? IDX_W : NUM_W;
  localparam logic [LNK_W-1:0] NONE = LNK_W'(POOL_SIZE);

  fsm_state_t       state_r, state_nxt;
  logic [LNK_W-1:0] free_head_r, free_head_nxt;
  logic [LNK_W-1:0] active_head_r, active_head_nxt;
  logic [IDX_W-1:0] cur_r, cur_nxt;
  logic [LNK_W-1:0] prev_r, prev_nxt;
  logic [NUM_W-1:0] want_r, want_nxt;
  logic [LNK_W-1:0] steps_r, steps_nxt;
  logic [LNK_W-1:0] link_r, link_nxt;
  res_word_t        res_r, res_nxt;

  logic             free_empty;
  logic             active_empty;
  logic             rd_is_none;
  logic             steps_end;
  logic             hit;

  assign free_empty   = (free_head_r >= NONE);
  assign active_empty = (active_head_r >= NONE);
  assign rd_is_none   = (rd_data >= NONE);
  assign steps_end    = ((steps_r + LNK_W'(1)) >= NONE);
  assign hit          = (CMP_W'(cur_r) == CMP_W'(want_r));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (mode_t'(in_mode))
            MODE_ALLOC:   state_nxt = free_empty ? S_EMIT : S_ALLOC;
            MODE_RELEASE: state_nxt = active_empty ? S_EMIT : S_REL_WALK;
            MODE_LIST:    state_nxt = active_empty ? S_EMIT : S_LIST;
            default:      state_nxt = S_IDLE;
          endcase
        end
      end
      S_ALLOC:      state_nxt = S_EMIT;
      S_REL_WALK: begin
        if (hit) begin
          state_nxt = S_REL_UNLINK;
        end else if (rd_is_none || steps_end) begin
          state_nxt = S_EMIT;
        end
      end
      S_REL_UNLINK: state_nxt = S_REL_FREE;
      S_REL_FREE:   state_nxt = S_EMIT;
      S_LIST: begin
        if (res_ready && (rd_is_none || steps_end)) begin
          state_nxt = S_IDLE;
        end
      end
      S_EMIT: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default:      state_nxt = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    free_head_nxt   = free_head_r;
    active_head_nxt = active_head_r;
    cur_nxt         = cur_r;
    prev_nxt        = prev_r;
    want_nxt        = want_r;
    steps_nxt       = steps_r;
    link_nxt        = link_r;
    res_nxt         = res_r;
    in_stall        = 1'b1;
    rd_en           = 1'b0;
    rd_addr         = cur_r;
    wr_en           = 1'b0;
    wr_addr         = cur_r;
    wr_data         = free_head_r;
    res_push        = 1'b0;
    res             = res_r;
    case (state_r)
      S_IDLE: begin
        in_stall  = 1'b0;
        steps_nxt = '0;
        prev_nxt  = NONE;
        want_nxt  = in_entry_number;
        if (in_valid) begin
          case (mode_t'(in_mode))
            MODE_ALLOC: begin
              res_nxt = '{num: '0, status: ST_EXHAUSTED, last: 1'b1};
              rd_en   = !free_empty;
              rd_addr = free_head_r[IDX_W-1:0];
              cur_nxt = free_head_r[IDX_W-1:0];
            end
            MODE_RELEASE: begin
              res_nxt = '{num: '0, status: ST_NOT_ACTIVE, last: 1'b1};
              rd_en   = !active_empty;
              rd_addr = active_head_r[IDX_W-1:0];
              cur_nxt = active_head_r[IDX_W-1:0];
            end
            MODE_LIST: begin
              res_nxt = '{num: '0, status: ST_EMPTY, last: 1'b1};
              rd_en   = !active_empty;
              rd_addr = active_head_r[IDX_W-1:0];
              cur_nxt = active_head_r[IDX_W-1:0];
            end
            default: begin
              res_nxt = res_r;
            end
          endcase
        end
      end
      S_ALLOC: begin
        // rd_data is the successor of the popped free entry
        wr_en           = 1'b1;
        wr_addr         = cur_r;
        wr_data         = active_head_r;
        free_head_nxt   = rd_data;
        active_head_nxt = LNK_W'(cur_r);
        res_nxt         = '{num: NUM_W'(cur_r), status: ST_OK, last: 1'b1};
      end
      S_REL_WALK: begin
        if (hit) begin
          link_nxt = rd_data;
        end else if (rd_is_none || steps_end) begin
          res_nxt = '{num: '0, status: ST_NOT_ACTIVE, last: 1'b1};
        end else begin
          rd_en     = 1'b1;
          rd_addr   = rd_data[IDX_W-1:0];
          prev_nxt  = LNK_W'(cur_r);
          cur_nxt   = rd_data[IDX_W-1:0];
          steps_nxt = steps_r + LNK_W'(1);
        end
      end
      S_REL_UNLINK: begin
        if (prev_r >= NONE) begin
          active_head_nxt = link_r;
        end else begin
          wr_en   = 1'b1;
          wr_addr = prev_r[IDX_W-1:0];
          wr_data = link_r;
        end
      end
      S_REL_FREE: begin
        wr_en         = 1'b1;
        wr_addr       = cur_r;
        wr_data       = free_head_r;
        free_head_nxt = LNK_W'(cur_r);
        res_nxt       = '{num: NUM_W'(cur_r), status: ST_OK, last: 1'b1};
      end
      S_LIST: begin
        res_push = res_ready;
        res      = '{num: NUM_W'(cur_r), status: ST_OK, last: rd_is_none || steps_end};
        if (res_ready && !(rd_is_none || steps_end)) begin
          rd_en     = 1'b1;
          rd_addr   = rd_data[IDX_W-1:0];
          cur_nxt   = rd_data[IDX_W-1:0];
          steps_nxt = steps_r + LNK_W'(1);
        end
      end
      S_EMIT: begin
        res_push = res_ready;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      free_head_r   <= '0;
      active_head_r <= NONE;
    end else begin
      state_r       <= state_nxt;
      free_head_r   <= free_head_nxt;
      active_head_r <= active_head_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r   <= cur_nxt;
    prev_r  <= prev_nxt;
    want_r  <= want_nxt;
    steps_r <= steps_nxt;
    link_r  <= link_nxt;
    res_r   <= res_nxt;
  end

endmodule

// File: rtl/linked_pool_entry_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linked_pool_entry_allocator
// free list / active list entry allocator over one shared link store
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | word
//  in_     | in  | in_valid/in_stall  | mode, entry_number
//  out_    | out | out_valid/out_stall| entry_number_res, status, last
//
//  allocate pops the free head onto the active list; release walks the active list,
//  then unlinks the entry and pushes it on the free list; list walks the active list
//  and gives one result word per active entry, through the registered link store read
//  reset is synchronous; the link store needs no clearing pass, as per-entry
//  valid bits make an unwritten entry read as its reset link
//  a new word is taken while a finished result still sits in the output register
//  a stalled output only holds up the sequencer when it has another result ready
// ----------------------------------------------------------------------------
module linked_pool_entry_allocator #(
  parameter int POOL_SIZE = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [lpa_pkg::MODE_W-1:0]    in_mode,
  input  logic [lpa_pkg::NUM_W-1:0]     in_entry_number,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [lpa_pkg::NUM_W-1:0]     out_entry_number_res,
  output logic [lpa_pkg::STAT_W-1:0]    out_status,
  output logic                          out_last
);

  import lpa_pkg::*;

  localparam int IDX_W = $clog2(POOL_SIZE);
  localparam int LNK_W = $clog2(POOL_SIZE + 1);

  // link store port
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic [LNK_W-1:0] rd_data;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [LNK_W-1:0] wr_data;

  // sequencer to output register
  logic             res_push;
  res_word_t        res;
  logic             res_ready;

  // output register
  logic             out_valid_r, out_valid_nxt;
  res_word_t        out_word_r, out_word_nxt;

  lpa_link_mem #(
    .POOL_SIZE (POOL_SIZE)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  lpa_ctrl #(
    .POOL_SIZE (POOL_SIZE)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_mode         (in_mode),
    .in_entry_number (in_entry_number),
    .rd_en           (rd_en),
    .rd_addr         (rd_addr),
    .rd_data         (rd_data),
    .wr_en           (wr_en),
    .wr_addr         (wr_addr),
    .wr_data         (wr_data),
    .res_push        (res_push),
    .res             (res),
    .res_ready       (res_ready)
  );

  // register is free when empty or being drained this cycle
  assign res_ready = !out_valid_r || !out_stall;

  always_comb begin
    out_word_nxt  = out_word_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (res_push) begin
      out_word_nxt  = res;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_entry_number_res = out_word_r.num;
  assign out_status           = out_word_r.status;
  assign out_last             = out_word_r.last;

endmodule

// File: rtl/lpa_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpa_checker
// port-level checks of the allocator, bound to the top level
// ----------------------------------------------------------------------------
module lpa_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic [lpa_pkg::MODE_W-1:0]    in_mode,
  input logic [lpa_pkg::NUM_W-1:0]     in_entry_number,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [lpa_pkg::NUM_W-1:0]     out_entry_number_res,
  input logic [lpa_pkg::STAT_W-1:0]    out_status,
  input logic                          out_last
);

  import lpa_pkg::*;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_entry_number_res)
      && $stable(out_status) && $stable(out_last))
    else $error("result word changed under stall");

  // error results carry entry zero
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> (out_entry_number_res == '0))
    else $error("error result with non-zero entry");

  // an error is always the only, and so final, result
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> out_last)
    else $error("error result without last");

  // any real request makes the sequencer stall the input, so no request is taken back to back
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_mode != MODE_UNUSED) |=> in_stall)
    else $error("request accepted back to back");

endmodule

bind linked_pool_entry_allocator lpa_checker u_lpa_checker (.*);

// File: bench/linked_pool_entry_allocator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linked_pool_entry_allocator_tb
// self-checking bench for the linked pool entry allocator: a queue-fed driver
// sends allocate, release and list requests, a transaction-level copy of the pool
// lists predicts every result word, and the monitor checks each word taken
// from the output against the oldest prediction
// ----------------------------------------------------------------------------
module linked_pool_entry_allocator_tb;

  import lpa_pkg::*;

  localparam int         POOL        = 32;
  localparam logic [5:0] NO_LINK     = 6'd32;
  localparam int         STALL_LIMIT = 4000;
  localparam int         CALM_TAIL   = 25;
  localparam int         DRAIN_WAIT  = 48;

  // free and active lists sharing one link store
  typedef struct packed {
    logic [POOL-1:0][5:0] link;
    logic [5:0]           free_head;
    logic [5:0]           active_head;
  } pool_t;

  // one request word waiting for the driver
  typedef struct packed {
    mode_t      mode;
    logic [4:0] num;
  } req_t;

  logic             clk             = 1'b0;
  logic             rst_n           = 1'b0;
  logic             in_valid        = 1'b0;
  logic             in_stall;
  logic [MODE_W-1:0] in_mode        = '0;
  logic [NUM_W-1:0] in_entry_number = '0;
  logic             out_valid;
  logic             out_stall       = 1'b0;
  logic [NUM_W-1:0] out_entry_number_res;
  logic [STAT_W-1:0] out_status;
  logic             out_last;

  req_t      pending[$];     // request words not yet presented
  res_word_t exp_words[$];   // predicted result words, oldest first
  pool_t     gen_pool;       // list state as seen while building stimulus
  pool_t     live_pool;      // list state as words are accepted
  req_t      next_req;
  int        n_items     = 0;
  int        mismatches  = 0;
  int        idle_cycles = 0;
  logic      in_took     = 1'b0;
  int        in_gap      = 0;
  int        out_gap     = 0;
  int        in_rate     = 1;
  int        out_rate    = 1;
  bit        filled      = 1'b0;
  int        sel;
  int        k;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  linked_pool_entry_allocator #(
    .POOL_SIZE(POOL)
  ) u_top (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_mode              (in_mode),
    .in_entry_number      (in_entry_number),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_entry_number_res (out_entry_number_res),
    .out_status           (out_status),
    .out_last             (out_last)
  );

  // ---------------------------------------------------------------------------
  // list model
  // ---------------------------------------------------------------------------

  function automatic pool_t pool_reset();
    pool_t s;
    for (int i = 0; i < POOL; i++) begin
      s.link[i] = 6'(i + 1);
    end
    s.link[POOL-1] = NO_LINK;
    s.free_head    = 6'd0;
    s.active_head  = NO_LINK;
    return s;
  endfunction

  function automatic void queue_word(input bit rec, input logic [4:0] num,
                                     input status_t st, input logic fin);
    res_word_t w;
    w.num    = num;
    w.status = st;
    w.last   = fin;
    if (rec) begin
      exp_words.push_back(w);
    end
  endfunction

  // applies one request to the lists; with rec set the result words are queued
  function automatic void pool_step(inout pool_t s, input mode_t m,
                                    input logic [4:0] num, input bit rec);
    logic [5:0] e;
    logic [5:0] prev;
    logic [5:0] cur;
    logic [5:0] nxt;
    int         steps;
    int         cnt;
    bit         found;
    case (m)
      MODE_ALLOC: begin
        e = s.free_head;
        if (e >= POOL) begin
          // pool exhausted, lists untouched
          queue_word(rec, 5'd0, ST_EXHAUSTED, 1'b1);
        end else begin
          s.free_head   = s.link[e];
          s.link[e]     = s.active_head;
          s.active_head = e;
          queue_word(rec, e[4:0], ST_OK, 1'b1);
        end
      end
      MODE_RELEASE: begin
        prev  = NO_LINK;
        cur   = s.active_head;
        steps = 0;
        found = 1'b0;
        while (!found && cur < POOL && steps < POOL) begin
          if (cur == {1'b0, num}) begin
            found = 1'b1;
          end else begin
            prev = cur;
            cur  = s.link[cur];
            steps++;
          end
        end
        if (found) begin
          // unlink from the active list, push on the free list
          if (prev >= POOL) begin
            s.active_head = s.link[cur];
          end else begin
            s.link[prev] = s.link[cur];
          end
          s.link[cur] = s.free_head;
          s.free_head = cur;
          queue_word(rec, cur[4:0], ST_OK, 1'b1);
        end else begin
          queue_word(rec, 5'd0, ST_NOT_ACTIVE, 1'b1);
        end
      end
      MODE_LIST: begin
        cur = s.active_head;
        if (cur >= POOL) begin
          queue_word(rec, 5'd0, ST_EMPTY, 1'b1);
        end else begin
          cnt = 0;
          while (cur < POOL && cnt < POOL) begin
            nxt = s.link[cur];
            queue_word(rec, cur[4:0], ST_OK, (nxt >= POOL) || (cnt + 1 >= POOL));
            cur = nxt;
            cnt++;
          end
        end
      end
      default: begin
        // unused code: no words, no change
      end
    endcase
  endfunction

  // random member of the active list, or any number when the list is empty
  function automatic logic [4:0] pick_active(input pool_t s);
    logic [4:0] hits[$];
    logic [5:0] cur;
    int         steps;
    cur   = s.active_head;
    steps = 0;
    while (cur < POOL && steps < POOL) begin
      hits.push_back(cur[4:0]);
      cur = s.link[cur];
      steps++;
    end
    if (hits.size() == 0) begin
      return 5'($urandom_range(0, 31));
    end
    return hits[$urandom_range(0, hits.size() - 1)];
  endfunction

  task automatic push_item(input mode_t m, input logic [4:0] num);
    req_t r;
    r.mode = m;
    r.num  = num;
    pending.push_back(r);
    pool_step(gen_pool, m, num, 1'b0);
    if (m != MODE_UNUSED) begin
      n_items++;
    end
  endtask

  function automatic logic [4:0] any_num();
    return 5'($urandom_range(0, 31));
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%s", msg);
    end
  endtask

  // ---------------------------------------------------------------------------
  // driver: presents queued words at the falling edge, with idle bursts
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin
    if (rst_n) begin
      // change the idling density now and then, rate 0 gives stretches with no idle bursts
      if ($urandom_range(0, 63) == 0) begin
        in_rate <= $urandom_range(0, 3);
      end
      if (!in_valid || in_took) begin
        if (in_gap != 0) begin
          in_gap   <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (pending.size() == 0) begin
          in_valid <= 1'b0;
        end else if (pending.size() > CALM_TAIL && in_rate != 0 &&
                     $urandom_range(1, 12) <= in_rate) begin
          // start a burst of idle cycles, this one included
          in_gap   <= $urandom_range(0, 14);
          in_valid <= 1'b0;
        end else begin
          next_req         = pending.pop_front();
          in_valid        <= 1'b1;
          in_mode         <= next_req.mode;
          in_entry_number <= next_req.num;
        end
      end
    end
  end

  // receiver stall bursts, none once the stimulus is nearly used up
  always @(negedge clk) begin
    if ($urandom_range(0, 63) == 0) begin
      out_rate <= $urandom_range(0, 3);
    end
    if (out_gap != 0) begin
      out_gap   <= out_gap - 1;
      out_stall <= 1'b1;
    end else if (pending.size() > CALM_TAIL && out_rate != 0 &&
                 $urandom_range(1, 12) <= out_rate) begin
      out_gap   <= $urandom_range(0, 14);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: predicts on every accepted request, checks every accepted result
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    res_word_t want;
    in_took <= rst_n && in_valid && !in_stall;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        pool_step(live_pool, mode_t'(in_mode), in_entry_number, 1'b1);
      end
      if (out_valid && !out_stall) begin
        if (exp_words.size() == 0) begin
          report_mismatch($sformatf("unexpected word: num %0d status %0d last %0d",
                                    out_entry_number_res, out_status, out_last));
        end else begin
          want = exp_words.pop_front();
          if (out_entry_number_res !== want.num || out_status !== want.status ||
              out_last !== want.last) begin
            report_mismatch($sformatf(
              "word mismatch: expected num %0d status %0d last %0d, got %0d %0d %0d",
              want.num, want.status, want.last,
              out_entry_number_res, out_status, out_last));
          end
        end
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (rst_n && !((in_valid && !in_stall) || (out_valid && !out_stall))) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == STALL_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end else begin
      idle_cycles <= 0;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------------

  initial begin
    gen_pool  = pool_reset();
    live_pool = pool_reset();

    // directed: empty lists, unused code, allocate then unlink head, middle, tail
    push_item(MODE_LIST, 5'd0);        // list with nothing active
    push_item(MODE_RELEASE, 5'd0);     // release on an empty active list
    push_item(MODE_RELEASE, 5'd31);
    push_item(MODE_UNUSED, 5'd31);     // ignored
    push_item(MODE_ALLOC, 5'd31);      // gets entry 0
    push_item(MODE_ALLOC, 5'd0);       // entry 1
    push_item(MODE_ALLOC, 5'd17);      // entry 2
    push_item(MODE_LIST, 5'd31);
    push_item(MODE_RELEASE, 5'd1);     // middle of the active list
    push_item(MODE_RELEASE, 5'd0);     // tail
    push_item(MODE_RELEASE, 5'd5);     // never allocated
    push_item(MODE_LIST, 5'd0);
    push_item(MODE_ALLOC, 5'd0);       // reuses the most recently freed entry
    push_item(MODE_RELEASE, 5'd0);     // head
    push_item(MODE_RELEASE, 5'd0);     // already free
    push_item(MODE_RELEASE, 5'd2);     // last active one
    push_item(MODE_LIST, 5'd0);
    push_item(MODE_UNUSED, 5'd0);

    // random: request sequences on live entries, at least one full fill, some noise
    while (n_items < 140) begin
      sel = $urandom_range(0, 11);
      if (sel == 0 || (!filled && n_items > 60)) begin
        // fill the pool, run past exhaustion, walk all 32, free a random share
        filled = 1'b1;
        while (gen_pool.free_head < POOL) begin
          push_item(MODE_ALLOC, any_num());
        end
        push_item(MODE_ALLOC, any_num());
        push_item(MODE_LIST, any_num());
        repeat ($urandom_range(8, 20)) begin
          push_item(MODE_RELEASE, pick_active(gen_pool));
        end
      end else if (sel == 1) begin
        // drain everything in random order
        while (gen_pool.active_head < POOL) begin
          push_item(MODE_RELEASE, pick_active(gen_pool));
        end
        push_item(MODE_LIST, any_num());
      end else if (sel < 10) begin
        k = $urandom_range(1, 6);
        repeat (k) begin
          push_item(MODE_ALLOC, any_num());
        end
        if ($urandom_range(0, 1) == 1) begin
          push_item(MODE_LIST, any_num());
        end
        repeat ($urandom_range(1, k)) begin
          if ($urandom_range(0, 4) == 0) begin
            push_item(MODE_RELEASE, any_num());
          end else begin
            push_item(MODE_RELEASE, pick_active(gen_pool));
          end
        end
      end else begin
        repeat (4) begin
          push_item(mode_t'($urandom_range(0, 3)), any_num());
        end
      end
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // wait for the last request to go in, then for every predicted word
    while (pending.size() != 0 || in_valid) @(negedge clk);
    while (exp_words.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);

    if (mismatches == 0 && exp_words.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/lpa_pkg.sv
rtl/lpa_link_mem.sv
rtl/lpa_ctrl.sv
rtl/linked_pool_entry_allocator.sv
rtl/lpa_checker.sv
bench/linked_pool_entry_allocator_tb.sv
